@@ sv/gats_pkg.sv @@
// shared widths, codes and command/status types of the tile splitter
package gats_pkg;

   localparam int MAX_FACTOR_DEF = 8;
   localparam int MAX_RESULTS    = 64;
   localparam int CNT_W          = $clog2(MAX_RESULTS);

   localparam int SIZE_W    = 13;
   localparam int OFF_W     = 12;
   localparam int HALO_W    = 8;
   localparam int BASE_W    = 12;
   localparam int INB_W     = 13;
   localparam int FACT_W    = 4;
   localparam int GRID_W    = 7;
   localparam int MAXT_W    = SIZE_W + 1;
   localparam int EDGE_W    = 4;
   localparam int CSR_IDX_W = 2;

   localparam int OFF_MAX = (1 << OFF_W) - 1;
   localparam int INB_MAX = (1 << INB_W) - 1;
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(4);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 2'd1;

   localparam logic [1:0] STEP_WF = 2'd0;
   localparam logic [1:0] STEP_GX = 2'd1;
   localparam logic [1:0] STEP_HF = 2'd2;
   localparam logic [1:0] STEP_GY = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic [1:0] div_step;
      logic       div_store;
      logic       walk_init;
      logic       tile_emit;
   } gats_cmd_type;

   typedef struct packed {
      logic zero_size;
      logic div_done;
      logic tile_last;
   } gats_status_type;

endpackage

@@ sv/gats_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
module gats_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gats_pkg::SIZE_W-1:0]  dividend,
   input  logic [gats_pkg::GRID_W-1:0]  divisor,
   output logic                         done,
   output logic [gats_pkg::SIZE_W-1:0]  quotient,
   output logic [gats_pkg::GRID_W-1:0]  remainder
);
   import gats_pkg::*;

   localparam int CW = $clog2(SIZE_W + 1);
   localparam logic [CW-1:0] DIV_STEPS = CW'(SIZE_W);

   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [GRID_W-1:0] rem_ff, rem_in;
   logic [GRID_W-1:0] div_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [GRID_W:0]   shift;
   logic [GRID_W:0]   diff;
   logic              fits;

   always_comb begin
      shift   = {rem_ff, quo_ff[SIZE_W-1]};
      diff    = shift - {1'b0, div_ff};
      fits    = shift >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SIZE_W-2:0], fits};
         rem_in = fits ? diff[GRID_W-1:0] : shift[GRID_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done longer than one cycle");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CW'(1)) |=> done_ff)
      else $error("divider finished without done");

endmodule

@@ sv/gats_datapath.sv @@
// request capture, tile size derivation and tile walk datapath
module gats_datapath #(
   parameter int MAX_FACTOR = gats_pkg::MAX_FACTOR_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gats_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gats_pkg::GRID_W-1:0]    csr_wdata,
   input  logic [gats_pkg::SIZE_W-1:0]    req_out_width,
   input  logic [gats_pkg::SIZE_W-1:0]    req_out_height,
   input  logic [gats_pkg::FACT_W-1:0]    req_width_factor,
   input  logic [gats_pkg::FACT_W-1:0]    req_height_factor,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_top,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_bottom,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_left,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_right,
   input  logic [gats_pkg::BASE_W-1:0]    req_inbound_bottom_base,
   input  logic [gats_pkg::BASE_W-1:0]    req_inbound_right_base,
   input  gats_pkg::gats_cmd_type         cmd,
   output gats_pkg::gats_status_type      status,
   output logic [gats_pkg::SIZE_W-1:0]    rsp_tile_cols,
   output logic [gats_pkg::SIZE_W-1:0]    rsp_tile_rows,
   output logic [gats_pkg::OFF_W-1:0]     rsp_offset_x,
   output logic [gats_pkg::OFF_W-1:0]     rsp_offset_y,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_top,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_bottom,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_left,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_right,
   output logic [gats_pkg::INB_W-1:0]     rsp_inbound_bottom,
   output logic [gats_pkg::INB_W-1:0]     rsp_inbound_right,
   output logic [gats_pkg::EDGE_W-1:0]    rsp_edge_mask,
   output logic                           rsp_last_tile
);
   import gats_pkg::*;

   function automatic logic [FACT_W-1:0] fix_factor(input logic [FACT_W-1:0] f);
      logic [FACT_W-1:0] v;
      v = f;
      if (v == '0) v = FACT_W'(1);
      if (int'(v) > MAX_FACTOR) v = FACT_W'(MAX_FACTOR);
      return v;
   endfunction

   function automatic logic [HALO_W-1:0] clamp_halo(input logic [HALO_W-1:0] halo,
                                                     input logic [SIZE_W-1:0] size);
      logic [HALO_W-1:0] v;
      v = ({{(SIZE_W-HALO_W){1'b0}}, halo} < size) ? halo : size[HALO_W-1:0];
      return v;
   endfunction

   function automatic logic [INB_W-1:0] sat_inbound(input logic [BASE_W-1:0] base,
                                                     input logic [SIZE_W-1:0] rest);
      logic [INB_W:0] sum;
      logic [INB_W-1:0] v;
      sum = (INB_W+1)'(base) + (INB_W+1)'(rest);
      v = (sum > (INB_W+1)'(INB_MAX)) ? INB_W'(INB_MAX) : sum[INB_W-1:0];
      return v;
   endfunction

   function automatic logic [OFF_W-1:0] sat_offset(input logic [SIZE_W-1:0] off);
      logic [OFF_W-1:0] v;
      v = (off > SIZE_W'(OFF_MAX)) ? OFF_W'(OFF_MAX) : off[OFF_W-1:0];
      return v;
   endfunction

   logic [SIZE_W-1:0] w_ff, h_ff;
   logic [FACT_W-1:0] wf_ff, hf_ff;
   logic [HALO_W-1:0] ht_ff, hb_ff, hl_ff, hr_ff;
   logic [BASE_W-1:0] bb_ff, rb_ff;
   logic [GRID_W-1:0] grid_x_ff, grid_y_ff;
   logic [GRID_W-1:0] gx, gy;
   logic [SIZE_W-1:0] q_ff, q_in;
   logic [MAXT_W-1:0] max_w_ff, max_h_ff, rounded;
   logic [SIZE_W-1:0] rows_left_ff, cols_left_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic              div_done;
   logic [SIZE_W-1:0] div_quo;
   logic [GRID_W-1:0] div_rem;
   logic [SIZE_W-1:0] div_dividend;
   logic [GRID_W-1:0] div_divisor;

   logic [SIZE_W-1:0] tw, th, cols_after, rows_after, ox, oy;
   logic              first_r, last_r, first_c, last_c, tile_last;

   assign gx = (grid_x_ff == '0) ? GRID_W'(1) : grid_x_ff;
   assign gy = (grid_y_ff == '0) ? GRID_W'(1) : grid_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_RESET;
         grid_y_ff <= GRID_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_GRID_X) grid_x_ff <= csr_wdata;
         if (csr_index == CSR_GRID_Y) grid_y_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         w_ff  <= req_out_width;
         h_ff  <= req_out_height;
         wf_ff <= fix_factor(req_width_factor);
         hf_ff <= fix_factor(req_height_factor);
         ht_ff <= req_halo_top;
         hb_ff <= req_halo_bottom;
         hl_ff <= req_halo_left;
         hr_ff <= req_halo_right;
         bb_ff <= req_inbound_bottom_base;
         rb_ff <= req_inbound_right_base;
      end
   end

   always_comb begin
      case (cmd.div_step)
         STEP_WF: begin
            div_dividend = w_ff;
            div_divisor  = GRID_W'(wf_ff);
         end
         STEP_GX: begin
            div_dividend = q_ff;
            div_divisor  = gx;
         end
         STEP_HF: begin
            div_dividend = h_ff;
            div_divisor  = GRID_W'(hf_ff);
         end
         default: begin
            div_dividend = q_ff;
            div_divisor  = gy;
         end
      endcase
   end

   gats_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ceiling of the first quotient, then round up to the grid
   always_comb begin
      q_in    = div_quo + SIZE_W'(div_rem != '0);
      rounded = (div_rem == '0) ? MAXT_W'(q_ff)
              : MAXT_W'(q_ff) + MAXT_W'(div_divisor) - MAXT_W'(div_rem);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_step)
            STEP_WF, STEP_HF: q_ff <= q_in;
            STEP_GX:          max_w_ff <= rounded;
            default:          max_h_ff <= rounded;
         endcase
      end
   end

   always_comb begin
      last_c     = MAXT_W'(cols_left_ff) <= max_w_ff;
      last_r     = MAXT_W'(rows_left_ff) <= max_h_ff;
      tw         = last_c ? cols_left_ff : max_w_ff[SIZE_W-1:0];
      th         = last_r ? rows_left_ff : max_h_ff[SIZE_W-1:0];
      cols_after = cols_left_ff - tw;
      rows_after = rows_left_ff - th;
      ox         = w_ff - cols_left_ff;
      oy         = h_ff - rows_left_ff;
      first_c    = cols_left_ff == w_ff;
      first_r    = rows_left_ff == h_ff;
      tile_last  = (last_r && last_c) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_left_ff <= '0;
         cols_left_ff <= '0;
         cnt_ff       <= '0;
      end else if (cmd.walk_init) begin
         rows_left_ff <= h_ff;
         cols_left_ff <= w_ff;
         cnt_ff       <= '0;
      end else if (cmd.tile_emit) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (last_c) begin
            cols_left_ff <= w_ff;
            rows_left_ff <= rows_after;
         end else begin
            cols_left_ff <= cols_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tile_emit) begin
         rsp_tile_cols        <= tw;
         rsp_tile_rows        <= th;
         rsp_offset_x         <= sat_offset(ox);
         rsp_offset_y         <= sat_offset(oy);
         rsp_tile_halo_top    <= first_r ? clamp_halo(ht_ff, th) : '0;
         rsp_tile_halo_bottom <= last_r ? clamp_halo(hb_ff, th) : '0;
         rsp_tile_halo_left   <= first_c ? clamp_halo(hl_ff, tw) : '0;
         rsp_tile_halo_right  <= last_c ? clamp_halo(hr_ff, tw) : '0;
         rsp_inbound_bottom   <= sat_inbound(bb_ff, rows_after);
         rsp_inbound_right    <= sat_inbound(rb_ff, cols_after);
         rsp_edge_mask        <= {last_c, first_c, last_r, first_r};
         rsp_last_tile        <= tile_last;
      end
   end

   always_comb begin
      status.zero_size = (req_out_width == '0) || (req_out_height == '0);
      status.div_done  = div_done;
      status.tile_last = tile_last;
   end

endmodule

@@ sv/gats_ctrl.sv @@
// controller state machine sequencing divisions and tile emission
module gats_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  gats_pkg::gats_status_type status,
   output gats_pkg::gats_cmd_type    cmd
);
   import gats_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.div_step  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !status.zero_size) begin
               cmd.capture = 1'b1;
               step_in     = STEP_WF;
               state_in    = S_START;
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (step_ff == STEP_GY) begin
                  cmd.walk_init = 1'b1;
                  state_in      = S_EMIT;
               end else begin
                  step_in  = step_ff + 2'd1;
                  state_in = S_START;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.tile_emit = 1'b1;
               if (status.tile_last) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.tile_emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_WF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.tile_emit && status.tile_last) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("last tile did not end the layer");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EMIT && !rsp_stall) |=> !rsp_valid_ff)
      else $error("transaction appeared outside emission");
   a_walk_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_init |-> (status.div_done && step_ff == STEP_GY))
      else $error("tile walk started before sizes were ready");

endmodule

@@ sv/grid_aligned_hw_tile_splitter.sv @@
// top level of the grid-aligned tile splitter
// sequencing: four iterative divisions run in turn on the one-bit-per-cycle divider
// before the first tile of a request transaction is emitted
// throughput: after the divisions, one tile per cycle while the response side does not stall;
// the next request is taken after the last tile is registered
// reset: synchronous; grid registers return to 4, no transaction pending
module grid_aligned_hw_tile_splitter #(
   parameter int MAX_FACTOR = gats_pkg::MAX_FACTOR_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gats_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gats_pkg::GRID_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gats_pkg::SIZE_W-1:0]    req_out_width,
   input  logic [gats_pkg::SIZE_W-1:0]    req_out_height,
   input  logic [gats_pkg::FACT_W-1:0]    req_width_factor,
   input  logic [gats_pkg::FACT_W-1:0]    req_height_factor,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_top,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_bottom,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_left,
   input  logic [gats_pkg::HALO_W-1:0]    req_halo_right,
   input  logic [gats_pkg::BASE_W-1:0]    req_inbound_bottom_base,
   input  logic [gats_pkg::BASE_W-1:0]    req_inbound_right_base,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gats_pkg::SIZE_W-1:0]    rsp_tile_cols,
   output logic [gats_pkg::SIZE_W-1:0]    rsp_tile_rows,
   output logic [gats_pkg::OFF_W-1:0]     rsp_offset_x,
   output logic [gats_pkg::OFF_W-1:0]     rsp_offset_y,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_top,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_bottom,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_left,
   output logic [gats_pkg::HALO_W-1:0]    rsp_tile_halo_right,
   output logic [gats_pkg::INB_W-1:0]     rsp_inbound_bottom,
   output logic [gats_pkg::INB_W-1:0]     rsp_inbound_right,
   output logic [gats_pkg::EDGE_W-1:0]    rsp_edge_mask,
   output logic                           rsp_last_tile
);
   import gats_pkg::*;

   gats_cmd_type    cmd;
   gats_status_type status;

   gats_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gats_datapath #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_out_width           (req_out_width),
      .req_out_height          (req_out_height),
      .req_width_factor        (req_width_factor),
      .req_height_factor       (req_height_factor),
      .req_halo_top            (req_halo_top),
      .req_halo_bottom         (req_halo_bottom),
      .req_halo_left           (req_halo_left),
      .req_halo_right          (req_halo_right),
      .req_inbound_bottom_base (req_inbound_bottom_base),
      .req_inbound_right_base  (req_inbound_right_base),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_tile_cols           (rsp_tile_cols),
      .rsp_tile_rows           (rsp_tile_rows),
      .rsp_offset_x            (rsp_offset_x),
      .rsp_offset_y            (rsp_offset_y),
      .rsp_tile_halo_top       (rsp_tile_halo_top),
      .rsp_tile_halo_bottom    (rsp_tile_halo_bottom),
      .rsp_tile_halo_left      (rsp_tile_halo_left),
      .rsp_tile_halo_right     (rsp_tile_halo_right),
      .rsp_inbound_bottom      (rsp_inbound_bottom),
      .rsp_inbound_right       (rsp_inbound_right),
      .rsp_edge_mask           (rsp_edge_mask),
      .rsp_last_tile           (rsp_last_tile)
   );

endmodule
